### rtl/sorted_insert_queue_top_macros.svh
// assertion helpers for the sorted insert queue
`ifndef SORTED_INSERT_QUEUE_TOP_MACROS_SVH
`define SORTED_INSERT_QUEUE_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SIQ_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("siq check failed");

// next-cycle implication, disabled while in reset
`define SIQ_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("siq check failed");

`endif

### rtl/siq_pkg.sv
`timescale 1ns / 1ps
package siq_pkg;

    localparam int DEPTH  = 32;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int SLOT_W = 5;
    localparam int OCC_W  = 6;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [31:0] key;
        logic [15:0]        tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        entry_t        wdata;
        logic [AW-1:0] raddr;
    } mem_req_t;

endpackage

### rtl/siq_ram.sv
`timescale 1ns / 1ps
module siq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/siq_ctrl.sv
`timescale 1ns / 1ps
module siq_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_req_type,
    input  logic signed [31:0]              s_key,
    input  logic [15:0]                     s_tag,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic signed [31:0]              m_out_key,
    output logic [15:0]                     m_out_tag,
    output logic [siq_pkg::SLOT_W-1:0]      m_slot,
    output logic [siq_pkg::OCC_W-1:0]       m_occupancy,
    output siq_pkg::mem_req_t               mem_req,
    input  siq_pkg::entry_t                 mem_rdata
);
    import siq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_UP_RD,
        S_UP_WR,
        S_WRITE_NEW,
        S_RM_HEAD,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      pos_reg;
    logic signed [31:0] key_reg;
    logic [15:0]        tag_reg;
    logic [1:0]         res_status_reg;
    logic signed [31:0] res_key_reg;
    logic [15:0]        res_tag_reg;
    logic [CW-1:0]      res_slot_reg;

    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic signed [31:0] m_out_key_reg;
    logic [15:0]        m_out_tag_reg;
    logic [SLOT_W-1:0]  m_slot_reg;
    logic [OCC_W-1:0]   m_occupancy_reg;

    logic [CW-1:0]      idx_dec;
    logic               is_full;
    logic               out_load;

    assign idx_dec  = idx_reg - CW'(1);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign s_ready  = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        mem_req       = '0;
        mem_req.wdata = mem_rdata;
        case (state_reg)
            S_SCAN_RD: begin
                mem_req.raddr = idx_reg[AW-1:0];
            end
            S_UP_RD: begin
                mem_req.raddr = idx_dec[AW-1:0];
            end
            S_UP_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg[AW-1:0];
            end
            S_WRITE_NEW: begin
                mem_req.we        = 1'b1;
                mem_req.waddr     = pos_reg[AW-1:0];
                mem_req.wdata.key = key_reg;
                mem_req.wdata.tag = tag_reg;
            end
            S_DN_RD: begin
                mem_req.raddr = idx_reg[AW-1:0];
            end
            S_DN_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_dec[AW-1:0];
            end
            default: begin
                // idle reads the head so a remove has it in the next cycle
                mem_req.raddr = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        key_reg        <= s_key;
                        tag_reg        <= s_tag;
                        res_status_reg <= ST_DONE;
                        res_key_reg    <= '0;
                        res_tag_reg    <= '0;
                        res_slot_reg   <= '0;
                        case (s_req_type)
                            REQ_APPEND: begin
                                if (is_full) begin
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_DONE;
                                end else begin
                                    pos_reg   <= count_reg;
                                    idx_reg   <= count_reg;
                                    state_reg <= S_UP_RD;
                                end
                            end
                            REQ_INSERT: begin
                                if (is_full) begin
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_DONE;
                                end else begin
                                    idx_reg   <= '0;
                                    state_reg <= S_SCAN_RD;
                                end
                            end
                            REQ_REMOVE: begin
                                if (count_reg == '0) begin
                                    res_status_reg <= ST_EMPTY;
                                    state_reg      <= S_DONE;
                                end else begin
                                    state_reg <= S_RM_HEAD;
                                end
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN_RD: begin
                    if (idx_reg == count_reg) begin
                        pos_reg   <= count_reg;
                        state_reg <= S_UP_RD;
                    end else begin
                        state_reg <= S_SCAN_CMP;
                    end
                end
                S_SCAN_CMP: begin
                    // strictly greater, so equal keys keep arrival order
                    if (mem_rdata.key > key_reg) begin
                        pos_reg   <= idx_reg;
                        idx_reg   <= count_reg;
                        state_reg <= S_UP_RD;
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_UP_RD: begin
                    if (idx_reg == pos_reg) begin
                        state_reg <= S_WRITE_NEW;
                    end else begin
                        state_reg <= S_UP_WR;
                    end
                end
                S_UP_WR: begin
                    idx_reg   <= idx_dec;
                    state_reg <= S_UP_RD;
                end
                S_WRITE_NEW: begin
                    count_reg    <= count_reg + CW'(1);
                    res_slot_reg <= pos_reg;
                    state_reg    <= S_DONE;
                end
                S_RM_HEAD: begin
                    res_key_reg <= mem_rdata.key;
                    res_tag_reg <= mem_rdata.tag;
                    idx_reg     <= CW'(1);
                    state_reg   <= S_DN_RD;
                end
                S_DN_RD: begin
                    if (idx_reg == count_reg) begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_DN_WR;
                    end
                end
                S_DN_WR: begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= S_DN_RD;
                end
                S_DONE: begin
                    // wait for the output register to free up
                    if (out_load) begin
                        m_status_reg    <= res_status_reg;
                        m_out_key_reg   <= res_key_reg;
                        m_out_tag_reg   <= res_tag_reg;
                        m_slot_reg      <= SLOT_W'(res_slot_reg);
                        m_occupancy_reg <= OCC_W'(count_reg);
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_key   = m_out_key_reg;
    assign m_out_tag   = m_out_tag_reg;
    assign m_slot      = m_slot_reg;
    assign m_occupancy = m_occupancy_reg;

endmodule

### rtl/sorted_insert_queue_top.sv
`timescale 1ns / 1ps
// Sorted insert queue: holds up to DEPTH (32) entries of signed key and tag in a
// RAM with registered read, kept in order by one sequencer that reads, compares
// and moves one entry at a time. An append writes the new entry at the tail. An
// ordered insert compares held entries from the head until one holds a strictly
// greater key, moves the entries from there on back by one slot, tail first, and
// writes the new entry into the freed slot. A remove reads the head and moves
// every other held entry forward by one slot. Full and empty rejects go straight
// to the done state. No item is taken while one is being worked on; a finished
// result waits in the output register without holding up the next item.
module sorted_insert_queue_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_req_type,
    input  logic signed [31:0]         s_key,
    input  logic [15:0]                s_tag,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic signed [31:0]         m_out_key,
    output logic [15:0]                m_out_tag,
    output logic [siq_pkg::SLOT_W-1:0] m_slot,
    output logic [siq_pkg::OCC_W-1:0]  m_occupancy
);
    import siq_pkg::*;

    `include "sorted_insert_queue_top_macros.svh"

    mem_req_t               mem_req;
    entry_t                 mem_rdata;
    logic [ENTRY_W-1:0]     ram_rdata;

    siq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_key       (s_key),
        .s_tag       (s_tag),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_key   (m_out_key),
        .m_out_tag   (m_out_tag),
        .m_slot      (m_slot),
        .m_occupancy (m_occupancy),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    siq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (ram_rdata)
    );

    assign mem_rdata = entry_t'(ram_rdata);

    // the RAM is only written while an item is in flight
    `SIQ_ASSERT_NOW(a_no_write_idle, aclk, aresetn, mem_req.we, !s_ready)
    // a full reject reports a full queue
    `SIQ_ASSERT_NOW(a_full_occ, aclk, aresetn, m_valid && (m_status == ST_FULL), m_occupancy == OCC_W'(DEPTH))
    // an empty reject reports nothing held and no data
    `SIQ_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_valid && (m_status == ST_EMPTY), (m_occupancy == '0) && (m_out_key == '0) && (m_out_tag == '0))
    // an accepted item keeps the queue from being ready again in the very next cycle
    `SIQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

### dv/sorted_insert_queue_top_tb.sv
`timescale 1ns / 1ps
module sorted_insert_queue_top_tb;
    import siq_pkg::*;

    localparam logic [1:0] REQ_NONE  = 2'd3;
    localparam int         RST_CYC   = 12;
    localparam int         STALL_LIM = 5000;
    localparam int         TAIL_CYC  = 100;
    localparam int         MAX_LINES = 40;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_key;
        logic [15:0]        out_tag;
        logic [SLOT_W-1:0]  slot;
        logic [OCC_W-1:0]   occupancy;
    } queue_result_t;

    typedef struct {
        logic [1:0]         req;
        logic signed [31:0] key;
        logic [15:0]        tag;
        int                 reps;
        bit                 typed;
        queue_result_t      want;
    } stim_row_t;

    logic                      aclk       = 1'b0;
    logic                      aresetn    = 1'b0;
    logic                      s_valid    = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_req_type = REQ_APPEND;
    logic signed [31:0]        s_key      = '0;
    logic [15:0]               s_tag      = '0;
    logic                      m_valid;
    logic                      m_ready    = 1'b0;
    logic [1:0]                m_status;
    logic signed [31:0]        m_out_key;
    logic [15:0]               m_out_tag;
    logic [SLOT_W-1:0]         m_slot;
    logic [OCC_W-1:0]          m_occupancy;

    // shadow copy of the queue contents
    logic signed [31:0] held_keys [DEPTH];
    logic [15:0]        held_tags [DEPTH];
    int                 held = 0;

    queue_result_t expected_results[$];
    stim_row_t     directed[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_errors       = 0;
    int n_sent         = 0;
    int n_full         = 0;
    int n_empty        = 0;
    int peak_fill      = 0;
    int stall_cycles   = 0;

    sorted_insert_queue_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_key       (s_key),
        .s_tag       (s_tag),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_key   (m_out_key),
        .m_out_tag   (m_out_tag),
        .m_slot      (m_slot),
        .m_occupancy (m_occupancy)
    );

    always #5 aclk = ~aclk;

    function automatic queue_result_t apply_request(input logic [1:0] req,
                                                    input logic signed [31:0] key,
                                                    input logic [15:0] tag);
        queue_result_t r;
        int            pos;
        r = '0;
        if (req == REQ_APPEND || req == REQ_INSERT) begin
            if (held == DEPTH) begin
                r.status = ST_FULL;
                n_full++;
            end else begin
                pos = held;
                // lowest index holding a strictly greater key wins
                if (req == REQ_INSERT) begin
                    for (int i = held - 1; i >= 0; i--) begin
                        if (held_keys[i] > key) begin
                            pos = i;
                        end
                    end
                end
                for (int i = held; i > pos; i--) begin
                    held_keys[i] = held_keys[i - 1];
                    held_tags[i] = held_tags[i - 1];
                end
                held_keys[pos] = key;
                held_tags[pos] = tag;
                held++;
                r.slot = pos[SLOT_W-1:0];
            end
        end else if (req == REQ_REMOVE) begin
            if (held == 0) begin
                r.status = ST_EMPTY;
                n_empty++;
            end else begin
                r.out_key = held_keys[0];
                r.out_tag = held_tags[0];
                for (int i = 1; i < held; i++) begin
                    held_keys[i - 1] = held_keys[i];
                    held_tags[i - 1] = held_tags[i];
                end
                held--;
            end
        end
        r.occupancy = held[OCC_W-1:0];
        if (held > peak_fill) begin
            peak_fill = held;
        end
        return r;
    endfunction

    function automatic stim_row_t stim(input logic [1:0] req, input logic [31:0] key,
                                       input logic [15:0] tag, input int reps,
                                       input bit typed, input logic [1:0] status,
                                       input logic [31:0] okey, input logic [15:0] otag,
                                       input int slot, input int occ);
        stim_row_t row;
        row.req            = req;
        row.key            = key;
        row.tag            = tag;
        row.reps           = reps;
        row.typed          = typed;
        row.want.status    = status;
        row.want.out_key   = okey;
        row.want.out_tag   = otag;
        row.want.slot      = slot[SLOT_W-1:0];
        row.want.occupancy = occ[OCC_W-1:0];
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_errors < MAX_LINES) begin
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        end
        n_errors++;
    endtask

    task automatic send_item(input logic [1:0] req, input logic signed [31:0] key,
                             input logic [15:0] tag, input bit typed,
                             input queue_result_t want);
        queue_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_key      <= key;
        s_tag      <= tag;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = apply_request(req, key, tag);
        expected_results.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // result side: random back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_status, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_out_key !== want.out_key)
                    report_mismatch("out_key", m_out_key, want.out_key);
                if (m_out_tag !== want.out_tag)
                    report_mismatch("out_tag", m_out_tag, want.out_tag);
                if (m_slot !== want.slot)
                    report_mismatch("slot", m_slot, want.slot);
                if (m_occupancy !== want.occupancy)
                    report_mismatch("occupancy", m_occupancy, want.occupancy);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIM) begin
            $display("sorted_insert_queue_top_tb: errors");
            $finish;
        end
    end

    initial begin
        int                 phase_items;
        int                 count;
        int                 mode;
        int                 pick;
        logic [1:0]         req;
        logic signed [31:0] key;

        // directed rows; typed expectations only where obvious
        directed.push_back(stim(REQ_REMOVE, 32'h0, 16'h0, 1, 1, ST_EMPTY, 0, 0, 0, 0));
        directed.push_back(stim(REQ_NONE, 32'h7fff_ffff, 16'hffff, 1, 1, ST_DONE, 0, 0, 0, 0));
        directed.push_back(stim(REQ_INSERT, 32'h0, 16'h0001, 1, 1, ST_DONE, 0, 0, 0, 1));
        directed.push_back(stim(REQ_INSERT, 32'h7fff_ffff, 16'hffff, 1, 1, ST_DONE, 0, 0, 1, 2));
        directed.push_back(stim(REQ_INSERT, 32'h8000_0000, 16'h0000, 1, 1, ST_DONE, 0, 0, 0, 3));
        // equal key lands behind the held one
        directed.push_back(stim(REQ_INSERT, 32'h0, 16'h0002, 1, 1, ST_DONE, 0, 0, 2, 4));
        directed.push_back(stim(REQ_APPEND, -32'sd5, 16'h0003, 1, 1, ST_DONE, 0, 0, 4, 5));
        directed.push_back(stim(REQ_INSERT, -32'sd5, 16'h0004, 1, 0, ST_DONE, 0, 0, 0, 0));
        directed.push_back(stim(REQ_INSERT, 32'h7fff_ffff, 16'h8000, 1, 0, ST_DONE, 0, 0, 0, 0));
        directed.push_back(stim(REQ_NONE, 32'h1234_5678, 16'h5a5a, 1, 1, ST_DONE, 0, 0, 0, 7));
        directed.push_back(stim(REQ_REMOVE, 32'h0, 16'h0, 1, 1,
                                ST_DONE, 32'h8000_0000, 16'h0000, 0, 6));
        directed.push_back(stim(REQ_REMOVE, 32'h0, 16'h0, 1, 0, ST_DONE, 0, 0, 0, 0));
        // fill up to the top
        directed.push_back(stim(REQ_APPEND, 32'h5555_5555, 16'haaaa, 27, 0, ST_DONE, 0, 0, 0, 0));
        directed.push_back(stim(REQ_INSERT, 32'h0, 16'h1234, 1, 1, ST_FULL, 0, 0, 0, 32));
        directed.push_back(stim(REQ_APPEND, 32'haaaa_aaaa, 16'h5555, 1, 1, ST_FULL, 0, 0, 0, 32));
        directed.push_back(stim(REQ_REMOVE, 32'h0, 16'h0, 1, 0, ST_DONE, 0, 0, 0, 0));
        directed.push_back(stim(REQ_INSERT, 32'h8000_0000, 16'h0101, 1, 0, ST_DONE, 0, 0, 0, 0));
        // drain past empty
        directed.push_back(stim(REQ_REMOVE, 32'hffff_ffff, 16'hffff, 33, 0, ST_DONE, 0, 0, 0, 0));

        send_idle_pct  = 12;
        recv_stall_pct = 65;
        repeat (RST_CYC) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            repeat (directed[i].reps) begin
                send_item(directed[i].req, directed[i].key, directed[i].tag,
                          directed[i].typed, directed[i].want);
            end
        end
        wait_for_drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 12 : (ph == 1) ? 65 : 0;
            recv_stall_pct = (ph == 0) ? 65 : (ph == 1) ? 12 : 0;
            phase_items    = (ph == 2) ? 450 : 440;
            count          = 0;
            mode           = 2;
            while (count < phase_items) begin
                // bursts that lean toward filling, draining, or a mix
                if (count % 40 == 0) begin
                    mode = $urandom_range(2);
                end
                pick = $urandom_range(99);
                if (pick < 3) begin
                    req = REQ_NONE;
                end else if (pick < ((mode == 0) ? 45 : (mode == 1) ? 20 : 38)) begin
                    req = REQ_INSERT;
                end else if (pick < ((mode == 0) ? 70 : (mode == 1) ? 30 : 66)) begin
                    req = REQ_APPEND;
                end else begin
                    req = REQ_REMOVE;
                end
                case ($urandom_range(9))
                    0: begin
                        key = 32'h8000_0000;
                    end
                    1: begin
                        key = 32'h7fff_ffff;
                    end
                    2, 3, 4: begin
                        // narrow range so equal keys are common
                        key = $signed($urandom_range(8)) - 4;
                    end
                    default: begin
                        key = $urandom();
                    end
                endcase
                send_item(req, key, 16'($urandom_range(16'hffff)), 1'b0, '0);
                if (req != REQ_NONE) begin
                    count++;
                end
                if ($urandom_range(199) == 0) begin
                    wait_for_drain();
                end
            end
            wait_for_drain();
        end

        repeat (TAIL_CYC) @(posedge aclk);
        if (expected_results.size() != 0) begin
            report_mismatch("results never delivered", expected_results.size(), 0);
        end
        $display("run covered %0d requests, %0d full rejects, %0d empty removes",
                 n_sent, n_full, n_empty);
        $display("peak fill %0d of %0d entries, %0d mismatches", peak_fill, DEPTH, n_errors);
        if (n_errors == 0) begin
            $display("sorted_insert_queue_top_tb: clean");
        end else begin
            $display("sorted_insert_queue_top_tb: errors");
        end
        $finish;
    end

endmodule
